### rtl/kvpt_pkg.sv
// Package for the key/value parameter tokenizer: transfer types, character
// constants and parser state codes.
// No dependencies.
package kvpt_pkg;

   localparam int FIELD_W        = 12;
   localparam int FIELD_MAX      = 4095;
   localparam int MAX_LINE_DFLT  = 4096;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_BRACE = 8'h7b;
   localparam logic [7:0] CH_EQ    = 8'h3d;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;

   typedef enum logic [10:0] {
      ST_WS_KEY       = 11'b000_0000_0001,
      ST_KEY          = 11'b000_0000_0010,
      ST_WS_AFTER_KEY = 11'b000_0000_0100,
      ST_EQ           = 11'b000_0000_1000,
      ST_WS_VAL       = 11'b000_0001_0000,
      ST_UNQ          = 11'b000_0010_0000,
      ST_OPEN_Q       = 11'b000_0100_0000,
      ST_QVAL         = 11'b000_1000_0000,
      ST_ESC          = 11'b001_0000_0000,
      ST_CLOSE_Q      = 11'b010_0000_0000,
      ST_ERR          = 11'b100_0000_0000
   } parse_state_type;

   typedef struct packed {
      logic       start_req;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic               pair_valid;
      logic [FIELD_W-1:0] key_start;
      logic [FIELD_W-1:0] key_len;
      logic [FIELD_W-1:0] value_start;
      logic [FIELD_W-1:0] val_len;
      logic               done_res;
      logic [FIELD_W-1:0] stop_pos;
      logic               in_error;
   } rsp_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
   endfunction

endpackage

### rtl/key_value_param_tokenizer.sv
// Key/value parameter tokenizer: one text byte per transfer, one result per byte; uses kvpt_pkg.
// The result is registered; throughput 1 byte per cycle while req_stall is low.
// The parser update is a one-hot state decode plus saturating 12-bit counters; the result
// sits in an output register backed by a one-entry skid register; input stalls only while the skid holds a result.
// Reset (synchronous, active high) returns the parser to whitespace-before-key, clears
// position and pair fields, and empties both result registers.
module key_value_param_tokenizer #(
   parameter int MAX_LINE = kvpt_pkg::MAX_LINE_DFLT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kvpt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kvpt_pkg::rsp_type rsp_data
);
   import kvpt_pkg::*;

   // Saturation limit for positions and lengths.
   localparam int LIMIT_INT = ((MAX_LINE - 1) < FIELD_MAX) ? (MAX_LINE - 1) : FIELD_MAX;
   localparam logic [FIELD_W-1:0] POS_LIMIT = LIMIT_INT[FIELD_W-1:0];

   function automatic logic [FIELD_W-1:0] sat_inc(input logic [FIELD_W-1:0] v);
      return (v < POS_LIMIT) ? (v + 1'b1) : POS_LIMIT;
   endfunction

   // Parser registers.
   parse_state_type    state_ff, state_in;
   logic [FIELD_W-1:0] pos_ff, pos_in;
   logic [FIELD_W-1:0] kstart_ff, kstart_in;
   logic [FIELD_W-1:0] klen_ff, klen_in;
   logic [FIELD_W-1:0] vstart_ff, vstart_in;
   logic [FIELD_W-1:0] vlen_ff, vlen_in;
   logic               fin_ff, fin_in;

   // Result registers: output stage and skid stage.
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_vld_ff, out_vld_in;
   logic    skid_vld_ff, skid_vld_in;

   // Values seen by the current byte (after an optional start).
   parse_state_type    cur_state;
   logic [FIELD_W-1:0] cur_pos, cur_kstart, cur_klen, cur_vstart, cur_vlen;
   logic               cur_fin;
   logic [7:0]         c;
   logic               brace;
   logic               emit;
   logic [FIELD_W-1:0] emit_vs, emit_vl;
   rsp_type            res;
   logic               acc, pop;

   assign acc       = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = skid_vld_ff;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;
   assign c         = req_data.ch;

   // Parser next state and result for the byte on the input.
   always_comb begin
      // A start request resets the parser ahead of this byte.
      if (req_data.start_req) begin
         cur_state  = ST_WS_KEY;
         cur_pos    = '0;
         cur_kstart = '0;
         cur_klen   = '0;
         cur_vstart = '0;
         cur_vlen   = '0;
         cur_fin    = 1'b0;
      end else begin
         cur_state  = state_ff;
         cur_pos    = pos_ff;
         cur_kstart = kstart_ff;
         cur_klen   = klen_ff;
         cur_vstart = vstart_ff;
         cur_vlen   = vlen_ff;
         cur_fin    = fin_ff;
      end

      state_in  = cur_state;
      pos_in    = cur_pos;
      kstart_in = cur_kstart;
      klen_in   = cur_klen;
      vstart_in = cur_vstart;
      vlen_in   = cur_vlen;
      fin_in    = cur_fin;
      brace     = 1'b0;
      emit      = 1'b0;
      emit_vs   = cur_vstart;
      emit_vl   = cur_vlen;
      res       = '0;

      if (cur_fin) begin
         // Stopped: hold everything, give an all-zero result.
      end else if (c == CH_NUL) begin
         fin_in       = 1'b1;
         res.done_res = 1'b1;
         res.stop_pos = cur_pos;
      end else begin
         unique case (cur_state)
            ST_WS_KEY: begin
               if (is_letter(c)) begin
                  kstart_in = cur_pos;
                  klen_in   = FIELD_W'(1);
                  state_in  = ST_KEY;
               end else if (c == CH_BRACE) begin
                  brace = 1'b1;
               end else if (c != CH_SPACE) begin
                  state_in = ST_ERR;
               end
            end
            ST_KEY: begin
               if (is_letter(c)) begin
                  klen_in = sat_inc(cur_klen);
               end else if (c == CH_SPACE) begin
                  state_in = ST_WS_AFTER_KEY;
               end else if (c == CH_EQ) begin
                  state_in = ST_EQ;
               end else begin
                  state_in = ST_ERR;
               end
            end
            ST_WS_AFTER_KEY: begin
               if (c == CH_EQ) begin
                  state_in = ST_EQ;
               end else if (c != CH_SPACE) begin
                  state_in = ST_ERR;
               end
            end
            ST_EQ, ST_WS_VAL: begin
               if (c == CH_SPACE) begin
                  state_in = ST_WS_VAL;
               end else if (c == CH_QUOTE) begin
                  state_in = ST_OPEN_Q;
               end else begin
                  vstart_in = cur_pos;
                  vlen_in   = FIELD_W'(1);
                  state_in  = ST_UNQ;
               end
            end
            ST_UNQ: begin
               if (c == CH_QUOTE) begin
                  state_in = ST_ERR;
               end else if (c == CH_SPACE) begin
                  emit     = 1'b1;
                  state_in = ST_WS_KEY;
               end else begin
                  vlen_in = sat_inc(cur_vlen);
               end
            end
            ST_OPEN_Q: begin
               if (c == CH_QUOTE) begin
                  // Empty quoted value: report zero start and length.
                  emit     = 1'b1;
                  emit_vs  = '0;
                  emit_vl  = '0;
                  state_in = ST_CLOSE_Q;
               end else begin
                  vstart_in = cur_pos;
                  vlen_in   = FIELD_W'(1);
                  state_in  = (c == CH_BSL) ? ST_ESC : ST_QVAL;
               end
            end
            ST_QVAL: begin
               if (c == CH_QUOTE) begin
                  emit     = 1'b1;
                  state_in = ST_CLOSE_Q;
               end else begin
                  vlen_in = sat_inc(cur_vlen);
                  if (c == CH_BSL) begin
                     state_in = ST_ESC;
                  end
               end
            end
            ST_ESC: begin
               if ((c == CH_QUOTE) || (c == CH_BSL)) begin
                  vlen_in  = sat_inc(cur_vlen);
                  state_in = ST_QVAL;
               end else begin
                  state_in = ST_ERR;
               end
            end
            ST_CLOSE_Q: begin
               if (c == CH_SPACE) begin
                  state_in = ST_WS_KEY;
               end else if (c == CH_BRACE) begin
                  brace = 1'b1;
               end else begin
                  state_in = ST_ERR;
               end
            end
            default: begin
               // Error state: wait for a brace.
               state_in = ST_ERR;
               brace    = (c == CH_BRACE);
            end
         endcase

         if (emit) begin
            res.pair_valid  = 1'b1;
            res.key_start   = cur_kstart;
            res.key_len     = cur_klen;
            res.value_start = emit_vs;
            res.val_len     = emit_vl;
            kstart_in       = '0;
            klen_in         = '0;
            vstart_in       = '0;
            vlen_in         = '0;
         end
         if (brace) begin
            fin_in       = 1'b1;
            res.done_res = 1'b1;
            res.stop_pos = sat_inc(cur_pos);
         end
         pos_in       = sat_inc(cur_pos);
         res.in_error = !fin_in && (state_in == ST_ERR);
      end
   end

   // Output and skid registers: a new result goes to the output stage when it
   // is free or draining, else to the skid stage.
   always_comb begin
      out_in      = out_ff;
      skid_in     = skid_ff;
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (acc) begin
         if (!out_vld_ff || pop) begin
            out_in     = res;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = res;
            skid_vld_in = 1'b1;
         end
      end else if (pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_WS_KEY;
         pos_ff      <= '0;
         kstart_ff   <= '0;
         klen_ff     <= '0;
         vstart_ff   <= '0;
         vlen_ff     <= '0;
         fin_ff      <= 1'b0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (acc) begin
            state_ff  <= state_in;
            pos_ff    <= pos_in;
            kstart_ff <= kstart_in;
            klen_ff   <= klen_in;
            vstart_ff <= vstart_in;
            vlen_ff   <= vlen_in;
            fin_ff    <= fin_in;
         end
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // A pair and a stop never come from the same byte.
   a_pair_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.pair_valid && rsp_data.done_res))
      else $error("pair and stop reported on one byte");

   // A stop result never flags the error state.
   a_done_not_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.in_error)
      else $error("stop reported with error flag");

   // The skid stage only fills behind a full output stage.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid stage holds a result with output stage empty");

   // Once stopped, further bytes without a start give no pair.
   a_fin_quiet: assert property (@(posedge clock) disable iff (reset)
      fin_ff && acc && !req_data.start_req |=> !(out_vld_ff && out_ff.pair_valid
         && !skid_vld_ff && $past(!out_vld_ff || pop)))
      else $error("pair reported after stop");

endmodule
